/* hdl/shadow_register_write_serializer_core_assert.svh */
// Assertion macros for the checker file of the serializer core.
`ifndef SHADOW_REGISTER_WRITE_SERIALIZER_CORE_ASSERT_SVH
`define SHADOW_REGISTER_WRITE_SERIALIZER_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define SRWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define SRWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define SRWS_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/srws_pkg.sv */
`default_nettype none

package srws_pkg;

    localparam int QUEUE_DEPTH   = 8;
    localparam int REPEAT_CYCLES = 2;
    localparam int NUM_REGS      = 6;

    localparam int DATA_W = 32;
    localparam int HALF_W = 16;
    localparam int IDX_W  = 3;
    localparam int MODE_W = 2;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RPT_W  = (REPEAT_CYCLES > 1) ? $clog2(REPEAT_CYCLES) : 1;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CQ_PTR_W   = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_WRITE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd2;

    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  reg_index;
        logic [DATA_W-1:0] write_value;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              word_valid;
        logic [HALF_W-1:0] bus_address;
        logic [HALF_W-1:0] bus_word;
        logic              rejected;
    } out_item_t;

    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  reg_index;
        logic [DATA_W-1:0] write_value;
    } cmd_t;

    // power-on contents of the shadow registers
    function automatic logic [DATA_W-1:0] reg_default(input logic [IDX_W-1:0] idx);
        logic [DATA_W-1:0] val;
        case (idx)
            3'd0:    val = 32'h0055_0000;
            3'd1:    val = 32'h0000_8011;
            3'd2:    val = 32'h1600_5E42;
            3'd3:    val = 32'h0000_04B3;
            3'd4:    val = 32'h008A_003C;
            3'd5:    val = 32'h0058_0005;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

/* hdl/srws_front.sv */
`default_nettype none

module srws_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               enable,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire srws_pkg::in_item_t s_item,
    output logic                    cmd_valid,
    input  wire logic               cmd_ready,
    output srws_pkg::cmd_t          cmd
);
    import srws_pkg::*;

    cmd_t                cls;
    logic                in_range;
    logic                push;
    logic                pop;
    cmd_t                cq_mem [CMDQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] cnt_reg, cnt_next;

    assign in_range = (s_item.reg_index < IDX_W'(NUM_REGS));

    // decode mode and range into one operation; disabled items become no-ops
    always_comb begin
        cls = '{op: OP_NOP, reg_index: s_item.reg_index, write_value: s_item.write_value};
        if (enable) begin
            unique case (s_item.mode)
                MODE_WRITE: cls.op = in_range ? OP_WRITE : OP_NOP;
                MODE_READ:  cls.op = in_range ? OP_READ : OP_NOP;
                MODE_TICK:  cls.op = OP_TICK;
                default:    cls.op = OP_NOP;
            endcase
        end
    end

    assign s_ready   = (cnt_reg != CQ_CNT_W'(CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = cq_mem[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            cq_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

/* hdl/srws_back.sv */
`default_nettype none

module srws_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          force_write,
    input  wire logic [srws_pkg::HALF_W-1:0]   device_address,
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  wire srws_pkg::cmd_t                cmd,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output srws_pkg::out_item_t                m_item
);
    import srws_pkg::*;

    logic [DATA_W-1:0] shadow_reg [NUM_REGS];
    logic [NUM_REGS-1:0] queued_reg, queued_next;
    logic [IDX_W-1:0]  pend_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              sending_reg, sending_next;
    logic [DATA_W-1:0] latched_reg, latched_next;
    logic              upper_reg, upper_next;
    logic [RPT_W-1:0]  rpt_reg, rpt_next;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic              exec;
    logic [IDX_W-1:0]  head_idx;
    logic [IDX_W-1:0]  deq_idx;
    logic [IDX_W-1:0]  rd_sel;
    logic [DATA_W-1:0] shadow_rd;
    logic              changed;
    logic              q_full;
    logic              tick_go;
    logic [DATA_W-1:0] cur_latched;
    logic              cur_upper;
    logic [RPT_W-1:0]  cur_rpt;
    logic              rpt_last;
    logic              do_push;
    logic              do_shadow_wr;
    out_item_t         res;

    assign cmd_ready = !out_valid_reg || m_ready;
    assign exec      = cmd_valid && cmd_ready;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_reg;

    assign head_idx = pend_reg[head_reg];
    assign deq_idx  = (head_idx < IDX_W'(NUM_REGS)) ? head_idx : '0;

    // one shared read port: the dequeued register on a tick, the addressed one otherwise
    assign rd_sel    = (cmd.op == OP_TICK) ? deq_idx : cmd.reg_index;
    assign shadow_rd = shadow_reg[rd_sel];

    assign changed  = (shadow_rd != cmd.write_value) || force_write;
    assign q_full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign tick_go  = sending_reg || (count_reg != '0);

    // a fresh dequeue starts at the low half, first copy
    assign cur_latched = sending_reg ? latched_reg : shadow_rd;
    assign cur_upper   = sending_reg && upper_reg;
    assign cur_rpt     = sending_reg ? rpt_reg : '0;
    assign rpt_last    = (cur_rpt == RPT_W'(REPEAT_CYCLES - 1));

    always_comb begin
        queued_next  = queued_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        sending_next = sending_reg;
        latched_next = latched_reg;
        upper_next   = upper_reg;
        rpt_next     = rpt_reg;
        do_push      = 1'b0;
        do_shadow_wr = 1'b0;
        res          = '0;
        if (exec) begin
            unique case (cmd.op)
                OP_WRITE: begin
                    if (changed) begin
                        if (q_full) begin
                            res.rejected = 1'b1;
                        end else begin
                            do_shadow_wr = 1'b1;
                            if (!queued_reg[cmd.reg_index]) begin
                                queued_next[cmd.reg_index] = 1'b1;
                                do_push    = 1'b1;
                                tail_next  = (tail_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                                             '0 : tail_reg + 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                end
                OP_READ: begin
                    res.read_data = shadow_rd;
                end
                OP_TICK: begin
                    if (tick_go) begin
                        if (!sending_reg) begin
                            queued_next[deq_idx] = 1'b0;
                            head_next    = (head_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                                           '0 : head_reg + 1'b1;
                            count_next   = count_reg - 1'b1;
                            latched_next = shadow_rd;
                        end
                        res.word_valid  = 1'b1;
                        res.bus_word    = cur_upper ? cur_latched[DATA_W-1:HALF_W]
                                                    : cur_latched[HALF_W-1:0];
                        res.bus_address = (cur_rpt == '0) ? device_address : '0;
                        sending_next    = 1'b1;
                        upper_next      = cur_upper;
                        if (rpt_last) begin
                            rpt_next = '0;
                            if (cur_upper) begin
                                sending_next = 1'b0;
                                upper_next   = 1'b0;
                            end else begin
                                upper_next = 1'b1;
                            end
                        end else begin
                            rpt_next = cur_rpt + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                shadow_reg[i] <= reg_default(IDX_W'(i));
            end
            queued_reg    <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            sending_reg   <= 1'b0;
            latched_reg   <= '0;
            upper_reg     <= 1'b0;
            rpt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (do_shadow_wr) begin
                shadow_reg[cmd.reg_index] <= cmd.write_value;
            end
            queued_reg  <= queued_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            sending_reg <= sending_next;
            latched_reg <= latched_next;
            upper_reg   <= upper_next;
            rpt_reg     <= rpt_next;
            if (cmd_ready) begin
                out_valid_reg <= cmd_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            pend_reg[tail_reg] <= cmd.reg_index;
        end
        if (cmd_ready) begin
            out_reg <= res;
        end
    end

endmodule

`default_nettype wire

/* hdl/shadow_register_write_serializer_core.sv */
// Shadow register write serializer core.
// Input channel s_valid/s_ready/s_item carries one item per handshake: a
// register write (mode 0), a register read (mode 1) or a bus tick (mode 2).
// Output channel m_valid/m_ready/m_item returns exactly one result item per
// input item in order: read data, a tick's bus word, a reject flag or zeros.
// Configuration (enable, force_write, device_address) is written through
// cfg_wr_en/cfg_addr/cfg_wr_data, one register per cycle; the user must
// write it only while idle; the block itself does not enforce this. An
// accepted item passes through the command queue, then the result register.
// Throughput: one item per cycle unless the receiver stalls; the back end
// executes items; it owns the shadow registers, pending queue, word sender.
// A two-entry command queue separates the front end from the back end, and a
// result register holds the output: when the receiver stalls, the back end
// stops and up to two further items are still accepted before s_ready drops.
// Reset (aresetn low, synchronous) loads the register defaults into the
// shadow registers, empties both queues, stops any word in flight and sets
// enable=1, force_write=0, device_address=0.
`default_nettype none

module shadow_register_write_serializer_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [srws_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [srws_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire srws_pkg::in_item_t               s_item,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output srws_pkg::out_item_t                   m_item
);
    import srws_pkg::*;

    // configuration registers
    logic              enable_reg;
    logic              force_write_reg;
    logic [HALF_W-1:0] dev_addr_reg;

    // front to back command handshake
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // Decode the write index; drop writes beyond the register list.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= 1'b1;
            force_write_reg <= 1'b0;
            dev_addr_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ENABLE:         enable_reg      <= cfg_wr_data[0];
                CFG_FORCE_WRITE:    force_write_reg <= cfg_wr_data[0];
                CFG_DEVICE_ADDRESS: dev_addr_reg    <= cfg_wr_data[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: classify each item and hold it in the command queue.
    srws_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (enable_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Back end: one command per cycle unless stalled; results are registered.
    srws_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .force_write    (force_write_reg),
        .device_address (dev_addr_reg),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item         (m_item)
    );

endmodule

`default_nettype wire

/* hdl/srws_checker.sv */
`default_nettype none
`include "shadow_register_write_serializer_core_assert.svh"

module srws_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire srws_pkg::out_item_t m_item
);
    import srws_pkg::*;

    `SRWS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_item), "result changed while stalled")

    `SRWS_ASSERT_NOW(a_rise_after_accept, aclk, aresetn, $rose(m_valid),
        $past(s_valid && s_ready, 2), "result without an item accepted two cycles before")

    `SRWS_ASSERT_NOW(a_no_word_zero, aclk, aresetn, m_valid && !m_item.word_valid,
        (m_item.bus_word == '0) && (m_item.bus_address == '0), "bus fields set without a word")

    `SRWS_ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_valid,
        "result valid right after reset")

endmodule

bind shadow_register_write_serializer_core srws_checker u_srws_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire

/* bench/testbench.sv */
module testbench;
    import srws_pkg::*;

    // Mode code that the block leaves unused; it must produce an all-zero result.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_LIMIT = 10;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_item;

    always #6 aclk = ~aclk;

    shadow_register_write_serializer_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    // Items waiting to be offered, and results still owed by the block.
    in_item_t pending_items [$];
    out_item_t outcome_q [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fault_count = 0;
    int cycle_count = 0;

    // ------------------------------------------------------------------
    // Shadow copy of the serializer: registers, dedupe marks, index FIFO,
    // the word sender and the three configuration registers.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] shadow_val [NUM_REGS];
    bit                queued_mark [NUM_REGS];
    logic [IDX_W-1:0]  index_fifo [$];
    bit                sending_now;
    logic [DATA_W-1:0] held_value;
    bit                high_half;
    int unsigned       copy_count;
    bit                cfg_enable;
    bit                cfg_force;
    logic [HALF_W-1:0] cfg_device;

    // Last value generated per register; reuse it to hit unchanged writes.
    logic [DATA_W-1:0] gen_last [NUM_REGS];

    function automatic logic [DATA_W-1:0] power_on_value(input int idx);
        logic [DATA_W-1:0] v;
        case (idx)
            0:       v = 32'h0055_0000;
            1:       v = 32'h0000_8011;
            2:       v = 32'h1600_5E42;
            3:       v = 32'h0000_04B3;
            4:       v = 32'h008A_003C;
            default: v = 32'h0058_0005;
        endcase
        return v;
    endfunction

    function automatic void reset_shadow();
        for (int i = 0; i < NUM_REGS; i++) begin
            shadow_val[i] = power_on_value(i);
            gen_last[i] = power_on_value(i);
            queued_mark[i] = 1'b0;
        end
        index_fifo.delete();
        sending_now = 1'b0;
        held_value = '0;
        high_half = 1'b0;
        copy_count = 0;
        cfg_enable = 1'b1;
        cfg_force = 1'b0;
        cfg_device = '0;
    endfunction

    // Apply one accepted item to the shadow copy and return the result it yields.
    function automatic out_item_t serialize_item(input in_item_t it);
        out_item_t r;
        logic [IDX_W-1:0] slot;
        r = '0;
        if (cfg_enable) begin
            if (it.mode == MODE_WRITE && it.reg_index < NUM_REGS) begin
                if (shadow_val[it.reg_index] != it.write_value || cfg_force) begin
                    // Drop the write when the FIFO is full, even for a queued index.
                    if (index_fifo.size() >= QUEUE_DEPTH) begin
                        r.rejected = 1'b1;
                    end else begin
                        shadow_val[it.reg_index] = it.write_value;
                        if (!queued_mark[it.reg_index]) begin
                            queued_mark[it.reg_index] = 1'b1;
                            index_fifo.push_back(it.reg_index);
                        end
                    end
                end
            end else if (it.mode == MODE_READ && it.reg_index < NUM_REGS) begin
                r.read_data = shadow_val[it.reg_index];
            end else if (it.mode == MODE_TICK && (sending_now || index_fifo.size() > 0)) begin
                // Latch the oldest queued register when the sender is free.
                if (!sending_now) begin
                    slot = index_fifo.pop_front();
                    held_value = shadow_val[slot];
                    queued_mark[slot] = 1'b0;
                    sending_now = 1'b1;
                    high_half = 1'b0;
                    copy_count = 0;
                end
                r.word_valid = 1'b1;
                r.bus_word = high_half ? held_value[31:16] : held_value[15:0];
                r.bus_address = (copy_count == 0) ? cfg_device : '0;
                copy_count++;
                if (copy_count >= REPEAT_CYCLES) begin
                    copy_count = 0;
                    if (high_half) begin
                        sending_now = 1'b0;
                        high_half = 1'b0;
                    end else begin
                        high_half = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    // Mostly well-formed writes and ticks; some reads, bad indexes and the unused mode.
    function automatic in_item_t random_item();
        in_item_t it;
        int pick;
        pick = $urandom_range(99);
        if (pick < 42) it.mode = MODE_WRITE;
        else if (pick < 56) it.mode = MODE_READ;
        else if (pick < 96) it.mode = MODE_TICK;
        else it.mode = MODE_UNUSED;
        it.reg_index = ($urandom_range(99) < 90) ? IDX_W'($urandom_range(5))
                                                 : IDX_W'($urandom_range(7, 6));
        pick = $urandom_range(99);
        if (pick < 22 && it.reg_index < NUM_REGS) it.write_value = gen_last[it.reg_index];
        else if (pick < 28) it.write_value = '0;
        else if (pick < 34) it.write_value = '1;
        else it.write_value = $urandom;
        if (it.mode == MODE_WRITE && it.reg_index < NUM_REGS)
            gen_last[it.reg_index] = it.write_value;
        return it;
    endfunction

    task automatic push_item(input logic [MODE_W-1:0] mode, input int idx,
                             input logic [DATA_W-1:0] value);
        in_item_t it;
        it.mode = mode;
        it.reg_index = idx[IDX_W-1:0];
        it.write_value = value;
        pending_items.push_back(it);
    endtask

    task automatic feed(input int count);
        repeat (count) pending_items.push_back(random_item());
    endtask

    // Hold until every item is offered, accepted and its result has come back.
    // Check away from the rising edge so the driver and monitor have settled.
    task automatic settle();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || outcome_q.size() != 0);
    endtask

    // Write one register while the block is idle and mirror it in the shadow copy.
    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_ENABLE:         cfg_enable = data[0];
            CFG_FORCE_WRITE:    cfg_force = data[0];
            CFG_DEVICE_ADDRESS: cfg_device = data;
            default: ;
        endcase
    endtask

    task automatic report_fault(input string why, input out_item_t want, input out_item_t got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%s: want rd=%h wv=%b ad=%h wd=%h rj=%b, got rd=%h wv=%b ad=%h wd=%h rj=%b",
                     why, want.read_data, want.word_valid, want.bus_address, want.bus_word,
                     want.rejected, got.read_data, got.word_valid, got.bus_address,
                     got.bus_word, got.rejected);
    endtask

    // ------------------------------------------------------------------
    // Driver: predict on each accepted item, then offer the next one or idle.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                outcome_q.push_back(serialize_item(s_item));
            // Advance only once the current item is gone; otherwise hold it.
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_item <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result with the oldest prediction; stall at random.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    report_fault("unexpected result", '0, m_item);
                end else begin
                    want = outcome_q.pop_front();
                    if (m_item.read_data !== want.read_data
                        || m_item.word_valid !== want.word_valid
                        || m_item.bus_address !== want.bus_address
                        || m_item.bus_word !== want.bus_word
                        || m_item.rejected !== want.rejected)
                        report_fault("wrong result", want, m_item);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // Watchdog: end a hung run.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("shadow_register_write_serializer_core: mismatch");
        $finish;
    end

    initial begin
        reset_shadow();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        program_reg(CFG_ENABLE, 16'd1);
        program_reg(CFG_FORCE_WRITE, 16'd0);
        program_reg(CFG_DEVICE_ADDRESS, 16'hFFFF);

        // Directed part: idle tick, reads of power-on values, unchanged write,
        // bad indexes, unused mode, update of a queued register, full send-out.
        push_item(MODE_TICK, 0, '0);
        for (int i = 0; i < NUM_REGS; i++) push_item(MODE_READ, i, '0);
        push_item(MODE_WRITE, 0, 32'h0055_0000);
        push_item(MODE_WRITE, 6, 32'hDEAD_BEEF);
        push_item(MODE_READ, 7, '0);
        push_item(MODE_UNUSED, 7, '1);
        push_item(MODE_WRITE, 5, 32'hFFFF_FFFF);
        push_item(MODE_WRITE, 5, 32'hFFFF_FFFE);
        push_item(MODE_WRITE, 0, 32'h0000_0000);
        push_item(MODE_READ, 5, '0);
        repeat (9) push_item(MODE_TICK, 3, '0);
        gen_last[5] = 32'hFFFF_FFFE;
        gen_last[0] = 32'h0000_0000;
        settle();

        // No idling; pause mid-phase until the block has drained.
        program_reg(CFG_DEVICE_ADDRESS, 16'($urandom));
        feed(125);
        settle();
        feed(125);
        settle();

        // Forced writes, bursty sender.
        send_idle_pct = 71;
        program_reg(CFG_FORCE_WRITE, 16'd1);
        program_reg(CFG_DEVICE_ADDRESS, 16'h0000);
        feed(250);
        settle();

        // Slow receiver.
        send_idle_pct = 0;
        recv_stall_pct = 71;
        program_reg(CFG_FORCE_WRITE, 16'd0);
        program_reg(CFG_DEVICE_ADDRESS, 16'h8000);
        feed(250);
        settle();

        // Both sides idle now and then.
        send_idle_pct = 19;
        recv_stall_pct = 19;
        program_reg(CFG_FORCE_WRITE, 16'd1);
        program_reg(CFG_DEVICE_ADDRESS, 16'($urandom));
        feed(250);
        settle();

        // Disabled: every item must come back all zero and leave state alone.
        program_reg(CFG_ENABLE, 16'd0);
        feed(60);
        settle();

        program_reg(CFG_ENABLE, 16'd1);
        program_reg(CFG_FORCE_WRITE, 16'd0);
        program_reg(CFG_DEVICE_ADDRESS, 16'h0001);
        feed(190);
        settle();

        repeat (8) @(posedge aclk);
        if (fault_count == 0) begin
            $display("shadow_register_write_serializer_core: match");
        end else begin
            $display("shadow_register_write_serializer_core: mismatch");
        end
        $finish;
    end

endmodule
